FILE: sv/tsd_pkg.sv
// Package for the streaming Targa decoder.
// Holds the result kinds, error codes and the result record type; no dependencies.
`default_nettype none

package tsd_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned TDATA_W = 80;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_IMAGE_TYPE = 2'd0;
    localparam logic [1:0] ERR_COLORMAP   = 2'd1;
    localparam logic [1:0] ERR_PIXEL_SIZE = 2'd2;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_GRAY      = 8'd3;
    localparam logic [7:0] TYPE_RLE       = 8'd10;

    localparam logic [7:0] BPP_8  = 8'd8;
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;

    localparam logic [7:0] OPAQUE      = 8'hff;
    localparam logic [7:0] RUN_FLAG    = 8'h80;
    localparam logic [7:0] RUN_LEN     = 8'h7f;
    localparam int unsigned FLIP_BIT   = 5;

    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_CMAP     = 5'd1;
    localparam logic [4:0] HDR_TYPE     = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HGT_LO   = 5'd14;
    localparam logic [4:0] HDR_HGT_HI   = 5'd15;
    localparam logic [4:0] HDR_BPP      = 5'd16;
    localparam logic [4:0] HDR_ATTR     = 5'd17;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_res;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        flip;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/tga_stream_decoder.sv
// Streaming Targa decoder, top level and only module.
// Depends on tsd_pkg for result kinds, codes and the result record.
//
// The block takes one byte of a Targa file per item on the s_ channel; s_tuser
// marks the first byte of a new file and restarts header parsing. After the
// 18-byte header it sends one header item (width, height, flip) or one error
// item, skips the ID field, and then sends RGBA pixel runs on the m_ channel,
// with m_tlast on the run that completes the image, or on the header item of
// an image with no pixels. m_tuser gives the kind. Each accepted byte is
// decoded in the cycle it is accepted and its result is registered in the
// output stage. One byte can be taken every cycle while s_tready is high.
// A two-entry output stage lets the block keep taking bytes while a result
// waits; s_tready drops only when both entries hold results. Bytes that give
// no result pass through whenever s_tready is high.
// A synchronous low aresetn empties the output stage and returns the parser
// to the header phase at byte zero.
`default_nettype none

module tga_stream_decoder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // in_byte
    input  wire logic [0:0]                   s_tuser,  // first
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // From bit 0: red, green, blue, alpha, repeat_res, image_width,
    // image_height, flip, error_code, zero fill.
    output logic [tsd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [tsd_pkg::KIND_W-1:0]        m_tuser,  // kind
    output logic                              m_tlast   // last
);
    import tsd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_IDSKIP = 3'd1;
    localparam logic [2:0] PH_RAW    = 3'd2;
    localparam logic [2:0] PH_PKTHDR = 3'd3;
    localparam logic [2:0] PH_PKTPIX = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  header_index_reg, header_index_next;
    logic [7:0]  id_skip_left_reg, id_skip_left_next;
    logic [7:0]  image_kind_reg, image_kind_next;
    logic        has_colormap_reg, has_colormap_next;
    logic [15:0] columns_reg, columns_next;
    logic [15:0] rows_reg, rows_next;
    logic [7:0]  bits_per_pixel_reg, bits_per_pixel_next;
    logic        flip_bit_reg, flip_bit_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0]  held_blue_reg, held_blue_next;
    logic [7:0]  held_green_reg, held_green_next;
    logic [7:0]  held_red_reg, held_red_next;

    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept;
    logic        pop;
    logic [7:0]  in_byte;
    logic [2:0]  eff_phase;
    logic [4:0]  eff_index;
    logic [31:0] area;
    logic [31:0] packet_left_ext;
    logic        run_active;
    logic [31:0] count;
    logic [31:0] left_after;
    logic [1:0]  pixel_bytes;
    logic [2:0]  data_phase;
    logic        res_valid;
    result_t     res;
    logic        size_ok;
    logic        emit;

    assign in_byte   = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;
    assign s_tready  = !skid_valid_reg;

    assign eff_phase = s_tuser[0] ? PH_HEADER : phase_reg;
    assign eff_index = s_tuser[0] ? HDR_ID_LEN : header_index_reg;

    assign area            = 32'(columns_reg) * 32'(rows_reg);
    assign packet_left_ext = 32'(packet_left_reg);
    assign run_active      = (eff_phase == PH_PKTPIX) && packet_is_run_reg;
    assign count           = run_active ? ((packet_left_ext > pixels_left_reg) ?
                                           pixels_left_reg : packet_left_ext) : 32'd1;
    assign left_after      = pixels_left_reg - count;
    assign data_phase      = (image_kind_reg == TYPE_RLE) ? PH_PKTHDR : PH_RAW;
    assign pixel_bytes     = (bits_per_pixel_reg == BPP_8)  ? 2'd1 :
                             (bits_per_pixel_reg == BPP_24) ? 2'd3 : 2'd0;
    assign size_ok         = (bits_per_pixel_reg == BPP_24) ||
                             (bits_per_pixel_reg == BPP_32) ||
                             ((bits_per_pixel_reg == BPP_8) && (image_kind_reg == TYPE_GRAY));

    always_comb begin
        phase_next          = eff_phase;
        header_index_next   = eff_index;
        id_skip_left_next   = id_skip_left_reg;
        image_kind_next     = image_kind_reg;
        has_colormap_next   = has_colormap_reg;
        columns_next        = columns_reg;
        rows_next           = rows_reg;
        bits_per_pixel_next = bits_per_pixel_reg;
        flip_bit_next       = flip_bit_reg;
        pixels_left_next    = pixels_left_reg;
        packet_left_next    = packet_left_reg;
        packet_is_run_next  = packet_is_run_reg;
        byte_in_pixel_next  = byte_in_pixel_reg;
        held_blue_next      = held_blue_reg;
        held_green_next     = held_green_reg;
        held_red_next       = held_red_reg;
        res_valid           = 1'b0;
        res                 = '0;
        emit                = 1'b0;

        unique case (eff_phase)
            PH_HEADER: begin
                case (eff_index)
                    HDR_ID_LEN:   id_skip_left_next   = in_byte;
                    HDR_CMAP:     has_colormap_next   = (in_byte != 8'd0);
                    HDR_TYPE:     image_kind_next     = in_byte;
                    HDR_WIDTH_LO: columns_next        = {8'd0, in_byte};
                    HDR_WIDTH_HI: columns_next        = {in_byte, columns_reg[7:0]};
                    HDR_HGT_LO:   rows_next           = {8'd0, in_byte};
                    HDR_HGT_HI:   rows_next           = {in_byte, rows_reg[7:0]};
                    HDR_BPP:      bits_per_pixel_next = in_byte;
                    HDR_ATTR:     flip_bit_next       = in_byte[FLIP_BIT];
                    default:      ;
                endcase
                if (eff_index >= HDR_ATTR) begin
                    header_index_next = HDR_ID_LEN;
                    res_valid         = 1'b1;
                    if ((image_kind_reg != TYPE_TRUECOLOR) && (image_kind_reg != TYPE_GRAY) &&
                        (image_kind_reg != TYPE_RLE)) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_IMAGE_TYPE;
                        phase_next     = PH_DONE;
                    end else if (has_colormap_reg) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_COLORMAP;
                        phase_next     = PH_DONE;
                    end else if (!size_ok) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_PIXEL_SIZE;
                        phase_next     = PH_DONE;
                    end else begin
                        pixels_left_next   = area;
                        packet_left_next   = 8'd0;
                        packet_is_run_next = 1'b0;
                        byte_in_pixel_next = 2'd0;
                        res.kind           = KIND_HEADER;
                        res.image_width    = columns_reg;
                        res.image_height   = rows_reg;
                        res.flip           = flip_bit_next;
                        if (area == 32'd0) begin
                            res.last   = 1'b1;
                            phase_next = PH_DONE;
                        end else if (id_skip_left_reg != 8'd0) begin
                            phase_next = PH_IDSKIP;
                        end else begin
                            phase_next = data_phase;
                        end
                    end
                end else begin
                    header_index_next = eff_index + 5'd1;
                end
            end
            PH_IDSKIP: begin
                if (id_skip_left_reg != 8'd0) begin
                    id_skip_left_next = id_skip_left_reg - 8'd1;
                end
                if (id_skip_left_next == 8'd0) begin
                    phase_next = data_phase;
                end
            end
            PH_RAW, PH_PKTPIX: begin
                res.alpha = OPAQUE;
                if (pixel_bytes == 2'd1) begin
                    emit      = 1'b1;
                    res.red   = in_byte;
                    res.green = in_byte;
                    res.blue  = in_byte;
                end else begin
                    case (byte_in_pixel_reg)
                        2'd0: begin
                            held_blue_next     = in_byte;
                            byte_in_pixel_next = 2'd1;
                        end
                        2'd1: begin
                            held_green_next    = in_byte;
                            byte_in_pixel_next = 2'd2;
                        end
                        2'd2: begin
                            if (pixel_bytes == 2'd3) begin
                                emit      = 1'b1;
                                res.red   = in_byte;
                                res.green = held_green_reg;
                                res.blue  = held_blue_reg;
                            end else begin
                                held_red_next      = in_byte;
                                byte_in_pixel_next = 2'd3;
                            end
                        end
                        default: begin
                            emit      = 1'b1;
                            res.red   = held_red_reg;
                            res.green = held_green_reg;
                            res.blue  = held_blue_reg;
                            res.alpha = in_byte;
                        end
                    endcase
                end
                if (emit) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_PIXEL;
                    res.repeat_res     = count[7:0];
                    res.last           = (left_after == 32'd0);
                    pixels_left_next   = left_after;
                    byte_in_pixel_next = 2'd0;
                    if (eff_phase == PH_PKTPIX) begin
                        if (packet_is_run_reg) begin
                            packet_left_next = 8'd0;
                        end else if (packet_left_reg != 8'd0) begin
                            packet_left_next = packet_left_reg - 8'd1;
                        end
                        if (packet_left_next == 8'd0) begin
                            phase_next = PH_PKTHDR;
                        end
                    end
                    if (left_after == 32'd0) begin
                        phase_next = PH_DONE;
                    end
                end else begin
                    res.alpha = 8'd0;
                end
            end
            PH_PKTHDR: begin
                packet_left_next   = (in_byte & RUN_LEN) + 8'd1;
                packet_is_run_next = ((in_byte & RUN_FLAG) != 8'd0);
                byte_in_pixel_next = 2'd0;
                phase_next         = PH_PKTPIX;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HEADER;
            header_index_reg   <= HDR_ID_LEN;
            id_skip_left_reg   <= '0;
            image_kind_reg     <= '0;
            has_colormap_reg   <= 1'b0;
            columns_reg        <= '0;
            rows_reg           <= '0;
            bits_per_pixel_reg <= '0;
            flip_bit_reg       <= 1'b0;
            pixels_left_reg    <= '0;
            packet_left_reg    <= '0;
            packet_is_run_reg  <= 1'b0;
            byte_in_pixel_reg  <= '0;
            held_blue_reg      <= '0;
            held_green_reg     <= '0;
            held_red_reg       <= '0;
        end else if (accept) begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            id_skip_left_reg   <= id_skip_left_next;
            image_kind_reg     <= image_kind_next;
            has_colormap_reg   <= has_colormap_next;
            columns_reg        <= columns_next;
            rows_reg           <= rows_next;
            bits_per_pixel_reg <= bits_per_pixel_next;
            flip_bit_reg       <= flip_bit_next;
            pixels_left_reg    <= pixels_left_next;
            packet_left_reg    <= packet_left_next;
            packet_is_run_reg  <= packet_is_run_next;
            byte_in_pixel_reg  <= byte_in_pixel_next;
            held_blue_reg      <= held_blue_next;
            held_green_reg     <= held_green_next;
            held_red_reg       <= held_red_next;
        end
    end

    // A new result goes to the main entry when it is free or drains now,
    // otherwise to the skid entry; the skid entry moves up when the main one drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept && res_valid) begin
                if (!out_valid_reg || pop) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'd0, out_reg.error_code, out_reg.flip, out_reg.image_height,
                       out_reg.image_width, out_reg.repeat_res, out_reg.alpha,
                       out_reg.blue, out_reg.green, out_reg.red};

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds a result while the main entry is empty.");

    a_pixel_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_PIXEL)) |-> (out_reg.repeat_res != 8'd0))
        else $error("Pixel run with a zero repeat count.");

    a_error_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERROR)) |-> !m_tlast)
        else $error("Error item marked as last.");

    a_packet_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PKTPIX) |-> (packet_left_reg != 8'd0))
        else $error("Packet pixel phase with no pixels left in the packet.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("Skid entry lost while the receiver stalls.");

endmodule

`default_nettype wire
